// ===== rtl/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants of the strongest beacon table
// Slot count, index widths, action codes, register indexes and the
// transaction structs passed between the table and the top level.
// ----------------------------------------------------------------------------
package sbt_pkg;

	localparam int SLOTS = 5;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ACT_REPORT = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_READ   = 2'd2
	} action_t;

	localparam logic [1:0] CFG_UUID0 = 2'd0;
	localparam logic [1:0] CFG_UUID1 = 2'd1;
	localparam logic [1:0] CFG_UUID2 = 2'd2;
	localparam logic [1:0] CFG_UUID3 = 2'd3;

	localparam logic [31:0] UUID0_RST = 32'hFDA50693;
	localparam logic [31:0] UUID1_RST = 32'hA4E24FB1;
	localparam logic [31:0] UUID2_RST = 32'hAFCFC6EB;
	localparam logic [31:0] UUID3_RST = 32'h07647825;

	localparam logic signed [7:0] STRENGTH_RST = -8'sd128;
	localparam logic signed [7:0] STRENGTH_MAX = 8'sd127;

	typedef struct packed {
		action_t           action;
		logic [3:0][31:0]  uuid;
		logic [15:0]       major;
		logic [15:0]       minor;
		logic signed [7:0] tx_power;
		logic signed [7:0] rssi;
		logic [2:0]        read_slot;
	} item_t;

	typedef struct packed {
		logic              accepted;
		logic              was_new;
		logic [2:0]        slot;
		logic [15:0]       major;
		logic [15:0]       minor;
		logic signed [7:0] tx_power;
		logic signed [7:0] rssi;
		logic              active;
		logic [2:0]        active_count;
	} result_t;

	// low three bits of a slot index
	function automatic logic [2:0] slot3(logic [IDX_W-1:0] idx);
		logic [IDX_W+2:0] ext;
		ext = {3'b000, idx};
		return ext[2:0];
	endfunction

	// low three bits of an active count
	function automatic logic [2:0] cnt3(logic [CNT_W-1:0] cnt);
		logic [CNT_W+2:0] ext;
		ext = {3'b000, cnt};
		return ext[2:0];
	endfunction

endpackage

// ===== rtl/sbt_uuid.sv =====
// ----------------------------------------------------------------------------
// sbt_uuid: UUID filter registers
// Holds the four configured UUID words and flags a report whose UUID equals
// them.
// ----------------------------------------------------------------------------
module sbt_uuid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  sbt_pkg::item_t item,
	output logic          uuid_ok
);
	import sbt_pkg::*;

	logic [3:0][31:0] uuid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uuid_q[0] <= UUID0_RST;
			uuid_q[1] <= UUID1_RST;
			uuid_q[2] <= UUID2_RST;
			uuid_q[3] <= UUID3_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UUID0: uuid_q[0] <= cfg_data;
				CFG_UUID1: uuid_q[1] <= cfg_data;
				CFG_UUID2: uuid_q[2] <= cfg_data;
				CFG_UUID3: uuid_q[3] <= cfg_data;
				default: uuid_q <= uuid_q;
			endcase
		end
	end

	assign uuid_ok = (item.uuid == uuid_q);

endmodule

// ===== rtl/sbt_table.sv =====
// ----------------------------------------------------------------------------
// sbt_table: beacon slot storage and update logic
// Finds the weakest and the matching slot in parallel, builds the result of
// the staged transaction and writes the slot registers when it commits.
// ----------------------------------------------------------------------------
module sbt_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  logic             uuid_ok,
	input  sbt_pkg::item_t   item,
	output sbt_pkg::result_t result
);
	import sbt_pkg::*;

	logic [15:0]       major_q    [SLOTS];
	logic [15:0]       minor_q    [SLOTS];
	logic signed [7:0] tx_power_q [SLOTS];
	logic signed [7:0] strength_q [SLOTS];
	logic [SLOTS-1:0]  active_q;

	logic signed [7:0] weakest;
	logic [IDX_W-1:0]  weak_idx;
	logic              match_found;
	logic [IDX_W-1:0]  match_idx;
	logic signed [7:0] avg [SLOTS];
	logic              take;
	logic              is_new;
	logic [IDX_W-1:0]  tgt;
	logic [IDX_W+2:0]  rd_ext;
	logic              rd_in;
	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  sel_idx;
	logic [SLOTS-1:0]  active_nxt;
	logic [CNT_W-1:0]  count_nxt;

	// weakest slot (lowest on ties), matching slot (highest on ties)
	always_comb begin
		weakest     = STRENGTH_MAX;
		weak_idx    = '0;
		match_found = 1'b0;
		match_idx   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (strength_q[i] < weakest) begin
				weakest  = strength_q[i];
				weak_idx = IDX_W'(i);
			end
			if (major_q[i] == item.major && minor_q[i] == item.minor) begin
				match_found = 1'b1;
				match_idx   = IDX_W'(i);
			end
		end
	end

	// per-slot average, halved toward zero
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			logic signed [8:0] sum9;
			logic signed [8:0] adj9;
			sum9   = {item.rssi[7], item.rssi} + {strength_q[i][7], strength_q[i]};
			adj9   = sum9 + {8'b0, sum9[8]};
			avg[i] = adj9[8:1];
		end
	end

	assign take   = (item.action == ACT_REPORT) && uuid_ok && (item.rssi > weakest);
	assign is_new = take && !match_found;
	assign tgt    = match_found ? match_idx : weak_idx;

	assign rd_ext  = {{IDX_W{1'b0}}, item.read_slot};
	assign rd_in   = rd_ext < (IDX_W + 3)'(SLOTS);
	assign rd_idx  = rd_ext[IDX_W-1:0];
	assign sel_idx = (item.action == ACT_READ) ? rd_idx : tgt;

	always_comb begin
		active_nxt = active_q;
		if (item.action == ACT_CLEAR) begin
			active_nxt = '0;
		end else if (is_new) begin
			active_nxt[tgt] = 1'b1;
		end
		count_nxt = '0;
		for (int i = 0; i < SLOTS; i++) begin
			count_nxt = count_nxt + CNT_W'(active_nxt[i]);
		end
	end

	always_comb begin
		result              = '0;
		result.active_count = cnt3(count_nxt);
		case (item.action)
			ACT_REPORT: begin
				if (take) begin
					result.accepted = 1'b1;
					result.was_new  = is_new;
					result.slot     = slot3(tgt);
					result.major    = item.major;
					result.minor    = item.minor;
					result.tx_power = item.tx_power;
					result.rssi     = is_new ? item.rssi : avg[sel_idx];
					result.active   = is_new | active_q[sel_idx];
				end
			end
			ACT_READ: begin
				result.slot = item.read_slot;
				if (rd_in) begin
					result.major    = major_q[sel_idx];
					result.minor    = minor_q[sel_idx];
					result.tx_power = tx_power_q[sel_idx];
					result.rssi     = strength_q[sel_idx];
					result.active   = active_q[sel_idx];
				end
			end
			default: begin
				result.accepted = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				major_q[i]    <= '0;
				minor_q[i]    <= '0;
				tx_power_q[i] <= '0;
				strength_q[i] <= STRENGTH_RST;
			end
			active_q <= '0;
		end else if (commit) begin
			active_q <= active_nxt;
			if (item.action == ACT_CLEAR) begin
				for (int i = 0; i < SLOTS; i++) begin
					major_q[i]    <= '0;
					minor_q[i]    <= '0;
					tx_power_q[i] <= '0;
					strength_q[i] <= STRENGTH_RST;
				end
			end else if (take) begin
				tx_power_q[tgt] <= item.tx_power;
				if (is_new) begin
					major_q[tgt]    <= item.major;
					minor_q[tgt]    <= item.minor;
					strength_q[tgt] <= item.rssi;
				end else begin
					strength_q[tgt] <= avg[tgt];
				end
			end
		end
	end

endmodule

// ===== rtl/strongest_beacon_table.sv =====
// ----------------------------------------------------------------------------
// strongest_beacon_table: table of the strongest beacons of one UUID
// Input register, single-pass slot search and update, result register.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while in_stall is low. A transaction is
// registered at acceptance and resolved against the five slots from the input
// register (weakest and matching slot searched in parallel, slot write and
// result produced together); its result is registered at commit. The result
// register decouples the sides: a new transaction is accepted while a finished
// result waits, and in_stall rises only when both input and result register
// are full and out_stall is high. The user must write UUID registers through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module strongest_beacon_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [31:0]       report_uuid0,
	input  logic [31:0]       report_uuid1,
	input  logic [31:0]       report_uuid2,
	input  logic [31:0]       report_uuid3,
	input  logic [15:0]       beacon_major,
	input  logic [15:0]       beacon_minor,
	input  logic signed [7:0] tx_power,
	input  logic signed [7:0] rssi,
	input  logic [2:0]        read_slot,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	output logic              was_new,
	output logic [2:0]        slot,
	output logic [15:0]       out_major,
	output logic [15:0]       out_minor,
	output logic signed [7:0] out_tx_power,
	output logic signed [7:0] out_rssi,
	output logic              out_active,
	output logic [2:0]        active_count
);
	import sbt_pkg::*;

	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    commit;
	logic    load_s1;
	logic    uuid_ok;

	always_comb begin
		item_in.action    = action_t'(action);
		item_in.uuid[0]   = report_uuid0;
		item_in.uuid[1]   = report_uuid1;
		item_in.uuid[2]   = report_uuid2;
		item_in.uuid[3]   = report_uuid3;
		item_in.major     = beacon_major;
		item_in.minor     = beacon_minor;
		item_in.tx_power  = tx_power;
		item_in.rssi      = rssi;
		item_in.read_slot = read_slot;
	end

	// result register free or draining this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign commit   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	sbt_uuid u_uuid (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_s1),
		.uuid_ok   (uuid_ok)
	);

	sbt_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.uuid_ok (uuid_ok),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!valid_s1 || advance) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= item_in;
		end
		if (commit) begin
			res_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = res_q.accepted;
	assign was_new      = res_q.was_new;
	assign slot         = res_q.slot;
	assign out_major    = res_q.major;
	assign out_minor    = res_q.minor;
	assign out_tx_power = res_q.tx_power;
	assign out_rssi     = res_q.rssi;
	assign out_active   = res_q.active;
	assign active_count = res_q.active_count;

	// hold input only when both stages are full and the consumer stalls
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("in_stall without a full pipeline");

	// a committed clear leaves an empty table in its result
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && item_s1.action == ACT_CLEAR) |=>
		(out_valid && active_count == 3'd0 && !accepted))
		else $error("clear transaction left active slots");

	// a new entry is always a written entry
	a_new_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!was_new || (accepted && out_active)))
		else $error("was_new without an accepted active write");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the strongest beacon table
// A queue-fed driver offers report, clear, read and unused-code transactions
// under random gaps; a table predictor computes each expected result at the
// input handshake and a monitor checks every result field under random stall.
// ----------------------------------------------------------------------------
module tb_top;
	import sbt_pkg::*;

	localparam int PHASE_ITEMS = 310;
	localparam int HOLD_AT     = 800;
	localparam int HOLD_LEN    = 400;
	localparam int QUIET_LIMIT = 4000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [1:0]        cfg_index    = '0;
	logic [31:0]       cfg_data     = '0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	item_t             drv_item     = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic              accepted;
	logic              was_new;
	logic [2:0]        slot;
	logic [15:0]       out_major;
	logic [15:0]       out_minor;
	logic signed [7:0] out_tx_power;
	logic signed [7:0] out_rssi;
	logic              out_active;
	logic [2:0]        active_count;

	// predictor copy of registers and table
	logic [31:0]       uuid_cfg [4];
	logic [15:0]       tbl_major [SLOTS];
	logic [15:0]       tbl_minor [SLOTS];
	logic signed [7:0] tbl_tx_power [SLOTS];
	logic signed [7:0] tbl_strength [SLOTS];
	logic              tbl_active [SLOTS];
	int                active_total;

	item_t   pending_q [$];
	result_t beacon_results_q [$];
	logic [15:0] pool_major [8];
	logic [15:0] pool_minor [8];
	int idle_pct     = 23;
	int mismatches   = 0;
	int results_seen = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	strongest_beacon_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (drv_item.action),
		.report_uuid0 (drv_item.uuid[0]),
		.report_uuid1 (drv_item.uuid[1]),
		.report_uuid2 (drv_item.uuid[2]),
		.report_uuid3 (drv_item.uuid[3]),
		.beacon_major (drv_item.major),
		.beacon_minor (drv_item.minor),
		.tx_power     (drv_item.tx_power),
		.rssi         (drv_item.rssi),
		.read_slot    (drv_item.read_slot),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.was_new      (was_new),
		.slot         (slot),
		.out_major    (out_major),
		.out_minor    (out_minor),
		.out_tx_power (out_tx_power),
		.out_rssi     (out_rssi),
		.out_active   (out_active),
		.active_count (active_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void clear_table();
		for (int i = 0; i < SLOTS; i++) begin
			tbl_major[i]    = '0;
			tbl_minor[i]    = '0;
			tbl_tx_power[i] = '0;
			tbl_strength[i] = STRENGTH_RST;
			tbl_active[i]   = 1'b0;
		end
		active_total = 0;
	endfunction

	function automatic result_t with_slot(input result_t r, input int s);
		result_t o;
		o          = r;
		o.major    = tbl_major[s];
		o.minor    = tbl_minor[s];
		o.tx_power = tbl_tx_power[s];
		o.rssi     = tbl_strength[s];
		o.active   = tbl_active[s];
		return o;
	endfunction

	// apply one transaction to the table copy and return its result
	function automatic result_t table_step(input item_t it);
		result_t r;
		logic    same;
		int      weakest;
		int      weak_idx;
		int      hit;
		int      s;
		int      sum;
		r = '0;
		case (it.action)
			ACT_REPORT: begin
				same = 1'b1;
				for (int k = 0; k < 4; k++)
					if (it.uuid[k] != uuid_cfg[k])
						same = 1'b0;
				weakest  = STRENGTH_MAX;
				weak_idx = 0;
				hit      = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_strength[i] < weakest) begin
						weakest  = tbl_strength[i];
						weak_idx = i;
					end
					if (tbl_major[i] == it.major && tbl_minor[i] == it.minor)
						hit = i;
				end
				if (same && int'(it.rssi) > weakest) begin
					if (hit < 0) begin
						s               = weak_idx;
						tbl_major[s]    = it.major;
						tbl_minor[s]    = it.minor;
						tbl_tx_power[s] = it.tx_power;
						tbl_strength[s] = it.rssi;
						tbl_active[s]   = 1'b1;
						r.was_new       = 1'b1;
					end else begin
						s               = hit;
						tbl_tx_power[s] = it.tx_power;
						sum             = int'(it.rssi) + int'(tbl_strength[s]);
						tbl_strength[s] = 8'(sum / 2);
					end
					active_total = 0;
					for (int i = 0; i < SLOTS; i++)
						active_total += int'(tbl_active[i]);
					r.accepted = 1'b1;
					r.slot     = 3'(s);
					r          = with_slot(r, s);
				end
			end
			ACT_CLEAR: begin
				clear_table();
			end
			ACT_READ: begin
				r.slot = it.read_slot;
				if (int'(it.read_slot) < SLOTS)
					r = with_slot(r, int'(it.read_slot));
			end
			default: ;
		endcase
		r.active_count = 3'(active_total);
		return r;
	endfunction

	// ------------------------------------------------------------------ driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				beacon_results_q.push_back(table_step(drv_item));
			if (!in_valid || !in_stall) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					drv_item <= pending_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ----------------------------------------------------------------- monitor
	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (beacon_results_q.size() == 0) begin
					$error("result transaction with nothing expected");
					mismatches++;
				end else begin
					want = beacon_results_q.pop_front();
					check_field("accepted", want.accepted, accepted);
					check_field("was_new", want.was_new, was_new);
					check_field("slot", want.slot, slot);
					check_field("out_major", want.major, out_major);
					check_field("out_minor", want.minor, out_minor);
					check_field("out_tx_power", int'(want.tx_power), int'(out_tx_power));
					check_field("out_rssi", int'(want.rssi), int'(out_rssi));
					check_field("out_active", want.active, out_active);
					check_field("active_count", want.active_count, active_count);
				end
				results_seen <= results_seen + 1;
			end
			// hold off once for a long stretch so the table backs up into its input
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (out_valid && !out_stall && results_seen == HOLD_AT) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_LEN;
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// --------------------------------------------------------------- stimulus
	function automatic item_t report_item(input logic [15:0] major, input logic [15:0] minor,
			input logic signed [7:0] txp, input logic signed [7:0] strength);
		item_t it;
		it          = '0;
		it.action   = ACT_REPORT;
		for (int k = 0; k < 4; k++)
			it.uuid[k] = uuid_cfg[k];
		it.major    = major;
		it.minor    = minor;
		it.tx_power = txp;
		it.rssi     = strength;
		return it;
	endfunction

	function automatic item_t cmd_item(input action_t act, input logic [2:0] rs);
		item_t it;
		it           = '0;
		it.action    = act;
		it.read_slot = rs;
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int    pick;
		int    k;
		pick = $urandom_range(99);
		it   = report_item(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
		it.read_slot = 3'($urandom_range(7));
		if (pick < 70) begin
			// well-formed report, identifiers mostly from a small pool so entries repeat
			if ($urandom_range(9) != 0) begin
				k = $urandom_range(7);
				it.major = pool_major[k];
				it.minor = pool_minor[k];
			end
		end else if (pick < 76) begin
			k = $urandom_range(3);
			it.uuid[k][$urandom_range(31)] = ~it.uuid[k][$urandom_range(31)];
			it.uuid[k] = it.uuid[k] ^ (32'h1 << $urandom_range(31));
		end else if (pick < 92) begin
			it.action = ACT_READ;
		end else if (pick < 94) begin
			it.action = ACT_CLEAR;
		end else if (pick < 96) begin
			it.action = action_t'(2'd3);
		end else begin
			for (k = 0; k < 4; k++)
				it.uuid[k] = $urandom;
		end
		return it;
	endfunction

	task automatic drain();
		while (pending_q.size() > 0 || in_valid || beacon_results_q.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_uuid(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we        <= 1'b1;
		cfg_index     <= idx;
		cfg_data      <= val;
		uuid_cfg[idx]  = val;
		@(posedge clk);
		cfg_we        <= 1'b0;
	endtask

	task automatic set_uuid(input logic [31:0] w0, input logic [31:0] w1,
			input logic [31:0] w2, input logic [31:0] w3);
		write_uuid(CFG_UUID0, w0);
		write_uuid(CFG_UUID1, w1);
		write_uuid(CFG_UUID2, w2);
		write_uuid(CFG_UUID3, w3);
		@(negedge clk);
	endtask

	task automatic run_random(input int n);
		pool_major[0] = '0;
		pool_minor[0] = '0;
		for (int k = 1; k < 8; k++) begin
			pool_major[k] = 16'($urandom);
			pool_minor[k] = 16'($urandom);
		end
		for (int i = 0; i < n; i++)
			pending_q.push_back(random_item());
		drain();
	endtask

	initial begin
		item_t bad;
		uuid_cfg[0] = UUID0_RST;
		uuid_cfg[1] = UUID1_RST;
		uuid_cfg[2] = UUID2_RST;
		uuid_cfg[3] = UUID3_RST;
		clear_table();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part against the reset UUID
		pending_q.push_back(cmd_item(ACT_READ, 3'd0));
		pending_q.push_back(report_item(16'h0BAD, 16'h0001, 8'sd3, -8'sd128));
		bad = report_item(16'h0BAD, 16'h0002, 8'sd3, 8'sd100);
		bad.uuid[3][0] = ~bad.uuid[3][0];
		pending_q.push_back(bad);
		// zero pair hits the highest never-written slot, average truncates toward zero
		pending_q.push_back(report_item(16'h0000, 16'h0000, 8'sd5, -8'sd100));
		pending_q.push_back(report_item(16'hFFFF, 16'hFFFF, -8'sd128, 8'sd127));
		pending_q.push_back(report_item(16'h1234, 16'h5678, 8'sd127, -8'sd127));
		pending_q.push_back(report_item(16'h1234, 16'h5678, -8'sd1, -8'sd2));
		pending_q.push_back(report_item(16'hAAAA, 16'h5555, 8'sd0, 8'sd1));
		pending_q.push_back(report_item(16'h5555, 16'hAAAA, 8'sd10, 8'sd3));
		pending_q.push_back(report_item(16'h0001, 16'h0002, -8'sd20, 8'sd0));
		pending_q.push_back(report_item(16'hFFFF, 16'hFFFF, 8'sd1, 8'sd127));
		// equal to the weakest: dropped
		pending_q.push_back(report_item(16'h7777, 16'h8888, 8'sd1, -8'sd64));
		for (int i = 0; i < 8; i++)
			pending_q.push_back(cmd_item(ACT_READ, 3'(i)));
		pending_q.push_back(cmd_item(action_t'(2'd3), 3'd7));
		pending_q.push_back(cmd_item(ACT_CLEAR, 3'd0));
		pending_q.push_back(cmd_item(ACT_READ, 3'd2));
		drain();

		run_random(PHASE_ITEMS);
		set_uuid('1, '1, '1, '1);
		run_random(PHASE_ITEMS);
		set_uuid($urandom, $urandom, $urandom, $urandom);
		run_random(PHASE_ITEMS);
		idle_pct = 0;
		set_uuid('0, '0, '0, '0);
		run_random(PHASE_ITEMS);
		idle_pct = 23;
		set_uuid($urandom, $urandom, $urandom, $urandom);
		run_random(PHASE_ITEMS);
		set_uuid('0, '1, $urandom, $urandom);
		run_random(PHASE_ITEMS);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
